// ===== rtl/core/hgcd_pkg.sv =====
package hgcd_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int ROM_LEN = 32;
    localparam int XW = 44;
    localparam int SQRT_STEPS = 32;
    localparam int LATENCY = 2 * CORDIC_ITERATIONS + 53;

    localparam logic REG_RADIUS = 1'b0;
    localparam logic [23:0] RADIUS_RESET = 24'd6371000;
    localparam logic [31:0] DIST_MAX = 32'd3373259426;

    localparam logic signed [63:0] ONE40 = 64'sd1 <<< 40;
    localparam logic [60:0] ONE60 = 61'd1 << 60;
    localparam logic signed [XW-1:0] ONE30 = XW'(64'sd1 <<< 30);

    localparam logic signed [33:0] DEG_FULL = 34'sd3019898880;
    localparam logic signed [33:0] DEG_HALF = 34'sd1509949440;
    localparam logic signed [33:0] DEG_QUART = 34'sd754974720;

    typedef logic [ROM_LEN-1:0][XW-1:0] atan_rom_t;

    typedef struct packed {
        logic tag;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
    } cordic_word_t;

    typedef struct packed {
        logic [63:0] v;
        logic [34:0] rem;
        logic [31:0] root;
    } sqrt_word_t;

    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] atan_inv(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] nn;
        logic [63:0] k;
        logic [63:0] term;
        logic signed [63:0] sum;
        p = udiv(64'h4000_0000_0000_0000, n);
        nn = n * n;
        k = '0;
        sum = '0;
        while (p != 64'd0)
        begin
            term = udiv(p, (k << 1) + 64'd1);
            if (k[0])
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
            p = udiv(p, nn);
            k = k + 64'd1;
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] mulshift(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input int sh);
        logic neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [127:0] p;
        logic [62:0] res;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        p = p + (128'd1 << (sh - 1));
        res = 63'(p >> sh);
        return neg ? -$signed({1'b0, res}) : $signed({1'b0, res});
    endfunction

    localparam logic signed [63:0] PI_Q60 = 4 * atan_inv(64'd5) - atan_inv(64'd239);
    localparam logic signed [63:0] DEG2RAD_Q60 = (PI_Q60 + 64'sd90) / 64'sd180;
    localparam logic signed [63:0] PI_Q40 = (PI_Q60 + (64'sd1 <<< 19)) >>> 20;

    function automatic atan_rom_t make_atan_rom();
        atan_rom_t rom;
        logic signed [63:0] val;
        for (int i = 0; i < ROM_LEN; i++)
        begin
            if (i == 0)
                val = (PI_Q60 + (64'sd1 <<< 21)) >>> 22;
            else
                val = (atan_inv(64'd1 << i) + (64'sd1 <<< 21)) >>> 22;
            rom[i] = val[XW-1:0];
        end
        return rom;
    endfunction

    function automatic logic signed [63:0] make_gain_inv();
        logic signed [63:0] prod;
        logic signed [63:0] y;
        logic signed [63:0] t;
        prod = ONE40;
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
            prod = prod + (prod >>> (2 * i));
        y = (64'sd3 * ONE40) / 64'sd5;
        for (int i = 0; i < 10; i++)
        begin
            t = mulshift(prod, mulshift(y, y, 40), 40);
            y = mulshift(y, 64'sd3 * ONE40 - t, 41);
        end
        return y;
    endfunction

    localparam atan_rom_t ATAN_ROM = make_atan_rom();
    localparam logic signed [63:0] GAIN_INV = make_gain_inv();

    function automatic logic signed [31:0] q40_to_q30(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = (v + XW'(512)) >>> 10;
        if (r > ONE30)
            r = ONE30;
        if (r < -ONE30)
            r = -ONE30;
        return 32'(r);
    endfunction

endpackage

// ===== rtl/core/hgcd_cordic_cell.sv =====
module hgcd_cordic_cell
    import hgcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vectoring,
    input  logic [4:0]         shift,
    input  logic [XW-1:0]      atan_step,
    input  logic               in_valid,
    input  cordic_word_t       in_word,
    output logic               out_valid,
    output cordic_word_t       out_word
);

    logic valid_reg;
    cordic_word_t word_reg;
    cordic_word_t word_next;
    logic pos;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb
    begin
        pos = vectoring ? in_word.y[XW-1] : ~in_word.z[XW-1];
        xs = $signed(in_word.x) >>> shift;
        ys = $signed(in_word.y) >>> shift;
        word_next.tag = in_word.tag;
        if (pos)
        begin
            word_next.x = $signed(in_word.x) - ys;
            word_next.y = $signed(in_word.y) + xs;
            word_next.z = $signed(in_word.z) - $signed(atan_step);
        end
        else
        begin
            word_next.x = $signed(in_word.x) + ys;
            word_next.y = $signed(in_word.y) - xs;
            word_next.z = $signed(in_word.z) + $signed(atan_step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word = word_reg;

endmodule

// ===== rtl/core/hgcd_sqrt_cell.sv =====
module hgcd_sqrt_cell
    import hgcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  sqrt_word_t  in_word,
    output logic        out_valid,
    output sqrt_word_t  out_word
);

    logic valid_reg;
    sqrt_word_t word_reg;
    sqrt_word_t word_next;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic ge;

    always_comb
    begin
        rem_sh = {in_word.rem[32:0], in_word.v[63:62]};
        trial = {1'b0, in_word.root, 2'b01};
        ge = rem_sh >= trial;
        word_next.rem = ge ? rem_sh - trial : rem_sh;
        word_next.root = {in_word.root[30:0], ge};
        word_next.v = {in_word.v[61:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word = word_reg;

endmodule

// ===== rtl/core/hgcd_mulsh.sv =====
module hgcd_mulsh
    import hgcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_tag,
    input  logic [63:0]        a_mag,
    input  logic [31:0]        b_mag,
    input  logic               neg,
    input  logic [5:0]         shamt,
    output logic               out_valid,
    output logic               out_tag,
    output logic signed [63:0] prod
);

    logic v1_reg;
    logic v2_reg;
    logic tag1_reg;
    logic tag2_reg;
    logic neg1_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic [96:0] rnd;
    logic [96:0] sum;
    logic [96:0] shifted;
    logic [62:0] res;

    always_comb
    begin
        rnd = (shamt == 6'd0) ? 97'd0 : (97'd1 << (shamt - 6'd1));
        sum = {1'b0, hi_reg, 32'd0} + {33'd0, lo_reg} + rnd;
        shifted = sum >> shamt;
        res = shifted[62:0];
        prod_next = neg1_reg ? -$signed({1'b0, res}) : $signed({1'b0, res});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= {32'd0, a_mag[63:32]} * {32'd0, b_mag};
        lo_reg <= {32'd0, a_mag[31:0]} * {32'd0, b_mag};
        neg1_reg <= neg;
        tag1_reg <= in_tag;
        tag2_reg <= tag1_reg;
        prod_reg <= prod_next;
    end

    assign out_valid = v2_reg;
    assign out_tag = tag2_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/core/haversine_great_circle_distance.sv =====
// Throughput: one word per cycle; busy stays low and start is taken on every cycle.
// Latency is set by the CORDIC cell chains, the 32-cell square-root chain and
// the split 32x32 multiplier stages.
// Reset clears all valid bits (results in flight are dropped) and loads the radius
// with 6371000; done cannot be held off by the receiver.
module haversine_great_circle_distance
    import hgcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [29:0] start_latitude,
    input  logic signed [30:0] start_longitude,
    input  logic signed [29:0] end_latitude,
    input  logic signed [30:0] end_longitude,
    output logic               done,
    output logic [31:0]        distance,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int N = CORDIC_ITERATIONS;

    logic [23:0] radius_reg;
    logic wr_en;

    logic a_valid_reg;
    logic signed [32:0] a_ang_reg [4];
    logic signed [32:0] a_ang_next [4];

    logic b_valid_reg;
    logic signed [30:0] b_r_reg [4];
    logic signed [30:0] b_r_next [4];
    logic b_cneg_reg [4];
    logic b_cneg_next [4];

    logic zc_valid [4];
    logic zc_tag [4];
    logic signed [63:0] zc_prod [4];

    cordic_word_t rot_word [4][N+1];
    logic rot_valid [4][N+1];

    logic rr_valid [4];
    logic rr_tag [4];
    logic signed [63:0] rr_prod [4];
    logic signed [XW-1:0] keep_d1_reg [4];
    logic signed [XW-1:0] keep_d2_reg [4];
    logic signed [XW-1:0] keep_next [4];

    logic c_valid_reg;
    logic signed [31:0] sc_reg [4];
    logic signed [31:0] sc_next [4];

    logic cc_valid;
    logic signed [63:0] cc_prod;
    logic signed [63:0] sq_prod;
    logic t_valid;
    logic signed [63:0] t_prod;
    logic tp_valid;
    logic signed [63:0] tp_prod;
    logic signed [31:0] s2_d_reg [4];
    logic [60:0] sq_d_reg [4];

    logic d_valid_reg;
    logic [60:0] d_a_reg;
    logic [60:0] d_b_reg;
    logic [60:0] d_a_next;
    logic signed [63:0] a_sum;

    sqrt_word_t sq_word [2][SQRT_STEPS+1];
    logic sq_valid [2][SQRT_STEPS+1];

    logic e_valid_reg;
    logic [31:0] e_root_reg [2];
    logic [31:0] e_root_next [2];

    cordic_word_t vec_word [N+1];
    logic vec_valid [N+1];

    logic g_valid;
    logic signed [63:0] g_prod;
    logic signed [XW-1:0] vz_d1_reg;
    logic signed [XW-1:0] vz_d2_reg;
    logic [XW-1:0] vy_mag;

    logic f_valid_reg;
    logic [41:0] f_ang_reg;
    logic [41:0] f_ang_next;
    logic signed [45:0] ang2;

    logic m_valid;
    logic signed [63:0] m_prod;

    logic done_reg;
    logic [31:0] distance_reg;
    logic [31:0] distance_next;

    assign busy = 1'b0;
    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_RADIUS) ? {8'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (wr_en && paddr[2] == REG_RADIUS)
            radius_reg <= pwdata[23:0];
    end

    always_comb
    begin
        a_ang_next[0] = 33'(end_latitude) - 33'(start_latitude);
        a_ang_next[1] = 33'(end_longitude) - 33'(start_longitude);
        a_ang_next[2] = 33'(start_latitude) <<< 1;
        a_ang_next[3] = 33'(end_latitude) <<< 1;
    end

    always_comb
    begin
        logic signed [33:0] w;
        logic signed [33:0] r;
        for (int k = 0; k < 4; k++)
        begin
            if (a_ang_reg[k] > DEG_HALF)
                w = 34'(a_ang_reg[k]) - DEG_FULL;
            else if (a_ang_reg[k] <= -DEG_HALF)
                w = 34'(a_ang_reg[k]) + DEG_FULL;
            else
                w = 34'(a_ang_reg[k]);
            b_cneg_next[k] = 1'b1;
            if (w > DEG_QUART)
                r = DEG_HALF - w;
            else if (w < -DEG_QUART)
                r = -DEG_HALF - w;
            else
            begin
                r = w;
                b_cneg_next[k] = 1'b0;
            end
            b_r_next[k] = 31'(r);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            a_ang_reg[k] <= a_ang_next[k];
            b_r_reg[k] <= b_r_next[k];
            b_cneg_reg[k] <= b_cneg_next[k];
        end
    end

    genvar k;
    genvar i;
    generate
        for (k = 0; k < 4; k++)
        begin : g_lane
            logic [31:0] r_mag;
            logic signed [XW-1:0] op;
            logic [XW-1:0] op_mag;
            logic [XW-1:0] z_mag;
            cordic_word_t tail;

            assign r_mag = b_r_reg[k][30] ? 32'(-b_r_reg[k]) : 32'(b_r_reg[k]);

            hgcd_mulsh u_zc (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (b_valid_reg),
                .in_tag    (b_cneg_reg[k]),
                .a_mag     (DEG2RAD_Q60),
                .b_mag     (r_mag),
                .neg       (b_r_reg[k][30]),
                .shamt     (6'd43),
                .out_valid (zc_valid[k]),
                .out_tag   (zc_tag[k]),
                .prod      (zc_prod[k])
            );

            assign rot_valid[k][0] = zc_valid[k];
            assign rot_word[k][0].tag = zc_tag[k];
            assign rot_word[k][0].x = GAIN_INV[XW-1:0];
            assign rot_word[k][0].y = '0;
            assign rot_word[k][0].z = zc_prod[k][XW-1:0];

            for (i = 0; i < N; i++)
            begin : g_cell
                hgcd_cordic_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .vectoring (1'b0),
                    .shift     (5'(i)),
                    .atan_step (ATAN_ROM[i]),
                    .in_valid  (rot_valid[k][i]),
                    .in_word   (rot_word[k][i]),
                    .out_valid (rot_valid[k][i+1]),
                    .out_word  (rot_word[k][i+1])
                );
            end

            assign tail = rot_word[k][N];

            always_comb
            begin
                if (k < 2)
                begin
                    op = $signed(tail.x);
                    keep_next[k] = $signed(tail.y);
                end
                else
                begin
                    op = $signed(tail.y);
                    keep_next[k] = $signed(tail.x);
                end
                op_mag = op[XW-1] ? XW'(-op) : XW'(op);
                z_mag = tail.z[XW-1] ? XW'(-$signed(tail.z)) : XW'($signed(tail.z));
            end

            hgcd_mulsh u_rr (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (rot_valid[k][N]),
                .in_tag    (tail.tag),
                .a_mag     (64'(op_mag)),
                .b_mag     (z_mag[31:0]),
                .neg       (op[XW-1] ^ tail.z[XW-1]),
                .shamt     (6'd40),
                .out_valid (rr_valid[k]),
                .out_tag   (rr_tag[k]),
                .prod      (rr_prod[k])
            );

            always_comb
            begin
                logic signed [31:0] q;
                if (k < 2)
                    q = q40_to_q30(keep_d2_reg[k] + rr_prod[k][XW-1:0]);
                else
                    q = q40_to_q30(keep_d2_reg[k] - rr_prod[k][XW-1:0]);
                if (k >= 2 && rr_tag[k])
                    sc_next[k] = -q;
                else
                    sc_next[k] = q;
            end

            always_ff @(posedge clk)
            begin
                keep_d1_reg[k] <= keep_next[k];
                keep_d2_reg[k] <= keep_d1_reg[k];
                sc_reg[k] <= sc_next[k];
            end
        end
    endgenerate

    logic [31:0] c1_mag;
    logic [31:0] c2_mag;
    logic [31:0] s1_mag;
    logic [31:0] cc_mag;
    logic [31:0] t_mag;
    logic [31:0] s2a_mag;
    logic [31:0] s2b_mag;

    always_comb
    begin
        c1_mag = sc_reg[2][31] ? 32'(-sc_reg[2]) : 32'(sc_reg[2]);
        c2_mag = sc_reg[3][31] ? 32'(-sc_reg[3]) : 32'(sc_reg[3]);
        s1_mag = sc_reg[0][31] ? 32'(-sc_reg[0]) : 32'(sc_reg[0]);
        cc_mag = cc_prod[63] ? 32'(-cc_prod) : 32'(cc_prod);
        t_mag = t_prod[63] ? 32'(-t_prod) : 32'(t_prod);
        s2a_mag = s2_d_reg[1][31] ? 32'(-s2_d_reg[1]) : 32'(s2_d_reg[1]);
        s2b_mag = s2_d_reg[3][31] ? 32'(-s2_d_reg[3]) : 32'(s2_d_reg[3]);
    end

    hgcd_mulsh u_cc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_tag    (1'b0),
        .a_mag     (64'(c1_mag)),
        .b_mag     (c2_mag),
        .neg       (sc_reg[2][31] ^ sc_reg[3][31]),
        .shamt     (6'd30),
        .out_valid (cc_valid),
        .out_tag   (),
        .prod      (cc_prod)
    );

    hgcd_mulsh u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_tag    (1'b0),
        .a_mag     (64'(s1_mag)),
        .b_mag     (s1_mag),
        .neg       (1'b0),
        .shamt     (6'd0),
        .out_valid (),
        .out_tag   (),
        .prod      (sq_prod)
    );

    hgcd_mulsh u_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cc_valid),
        .in_tag    (1'b0),
        .a_mag     (64'(cc_mag)),
        .b_mag     (s2a_mag),
        .neg       (cc_prod[63] ^ s2_d_reg[1][31]),
        .shamt     (6'd30),
        .out_valid (t_valid),
        .out_tag   (),
        .prod      (t_prod)
    );

    hgcd_mulsh u_tp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_tag    (1'b0),
        .a_mag     (64'(t_mag)),
        .b_mag     (s2b_mag),
        .neg       (t_prod[63] ^ s2_d_reg[3][31]),
        .shamt     (6'd0),
        .out_valid (tp_valid),
        .out_tag   (),
        .prod      (tp_prod)
    );

    always_ff @(posedge clk)
    begin
        s2_d_reg[0] <= sc_reg[1];
        sq_d_reg[0] <= sq_prod[60:0];
        for (int j = 1; j < 4; j++)
        begin
            s2_d_reg[j] <= s2_d_reg[j-1];
            sq_d_reg[j] <= sq_d_reg[j-1];
        end
    end

    always_comb
    begin
        a_sum = $signed({3'd0, sq_d_reg[3]}) + tp_prod;
        if (a_sum < 0)
            d_a_next = '0;
        else if (a_sum > $signed({3'd0, ONE60}))
            d_a_next = ONE60;
        else
            d_a_next = a_sum[60:0];
    end

    always_ff @(posedge clk)
    begin
        d_a_reg <= d_a_next;
        d_b_reg <= ONE60 - d_a_next;
    end

    assign sq_valid[0][0] = d_valid_reg;
    assign sq_word[0][0].v = {3'd0, d_b_reg};
    assign sq_word[0][0].rem = '0;
    assign sq_word[0][0].root = '0;
    assign sq_valid[1][0] = d_valid_reg;
    assign sq_word[1][0].v = {3'd0, d_a_reg};
    assign sq_word[1][0].rem = '0;
    assign sq_word[1][0].root = '0;

    genvar q;
    generate
        for (q = 0; q < 2; q++)
        begin : g_sqrt
            for (i = 0; i < SQRT_STEPS; i++)
            begin : g_cell
                hgcd_sqrt_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (sq_valid[q][i]),
                    .in_word   (sq_word[q][i]),
                    .out_valid (sq_valid[q][i+1]),
                    .out_word  (sq_word[q][i+1])
                );
            end

            assign e_root_next[q] = sq_word[q][SQRT_STEPS].root
                + 32'(sq_word[q][SQRT_STEPS].rem > {3'd0, sq_word[q][SQRT_STEPS].root});

            always_ff @(posedge clk)
            begin
                e_root_reg[q] <= e_root_next[q];
            end
        end
    endgenerate

    assign vec_valid[0] = e_valid_reg;
    assign vec_word[0].tag = 1'b0;
    assign vec_word[0].x = XW'({e_root_reg[0], 10'd0});
    assign vec_word[0].y = XW'({e_root_reg[1], 10'd0});
    assign vec_word[0].z = '0;

    generate
        for (i = 0; i < N; i++)
        begin : g_vec
            hgcd_cordic_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .vectoring (1'b1),
                .shift     (5'(i)),
                .atan_step (ATAN_ROM[i]),
                .in_valid  (vec_valid[i]),
                .in_word   (vec_word[i]),
                .out_valid (vec_valid[i+1]),
                .out_word  (vec_word[i+1])
            );
        end
    endgenerate

    assign vy_mag = vec_word[N].y[XW-1] ? XW'(-$signed(vec_word[N].y))
                                        : XW'($signed(vec_word[N].y));

    hgcd_mulsh u_g (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid[N]),
        .in_tag    (1'b0),
        .a_mag     (GAIN_INV),
        .b_mag     (vy_mag[31:0]),
        .neg       (vec_word[N].y[XW-1]),
        .shamt     (6'd40),
        .out_valid (g_valid),
        .out_tag   (),
        .prod      (g_prod)
    );

    always_comb
    begin
        ang2 = (46'(vz_d2_reg) + 46'(g_prod)) <<< 1;
        if (ang2 < 0)
            f_ang_next = '0;
        else if (ang2 > 46'(PI_Q40))
            f_ang_next = PI_Q40[41:0];
        else
            f_ang_next = ang2[41:0];
    end

    always_ff @(posedge clk)
    begin
        vz_d1_reg <= $signed(vec_word[N].z);
        vz_d2_reg <= vz_d1_reg;
        f_ang_reg <= f_ang_next;
    end

    hgcd_mulsh u_rad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .in_tag    (1'b0),
        .a_mag     ({22'd0, f_ang_reg}),
        .b_mag     ({8'd0, radius_reg}),
        .neg       (1'b0),
        .shamt     (6'd34),
        .out_valid (m_valid),
        .out_tag   (),
        .prod      (m_prod)
    );

    always_comb
    begin
        if (m_prod < 0)
            distance_next = '0;
        else if (m_prod > $signed({32'd0, DIST_MAX}))
            distance_next = DIST_MAX;
        else
            distance_next = m_prod[31:0];
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= distance_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start & ~busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= rr_valid[0];
            d_valid_reg <= tp_valid;
            e_valid_reg <= sq_valid[0][SQRT_STEPS];
            f_valid_reg <= g_valid;
            done_reg <= m_valid;
        end
    end

    assign done = done_reg;
    assign distance = distance_reg;

    assert property (@(posedge clk) disable iff (!rst_n) start |-> ##LATENCY done)
        else $error("accepted word did not complete on schedule");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(start, LATENCY))
        else $error("result without matching accepted word");

    assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> (e_root_reg[0] <= 32'h4000_0000 && e_root_reg[1] <= 32'h4000_0000))
        else $error("square root out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg |-> ({22'd0, f_ang_reg} <= PI_Q40))
        else $error("central angle above pi");

    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (d_a_reg + d_b_reg == ONE60))
        else $error("haversine terms do not sum to one");

endmodule

// ===== verif/haversine_great_circle_distance_tb.sv =====
`timescale 1ns / 100ps

module haversine_great_circle_distance_tb;
    import hgcd_pkg::*;

    localparam longint DEG = 64'sd1 <<< 22;
    localparam longint LAT_LIM = 64'sd377487360;
    localparam longint LON_LIM = 64'sd754974720;
    localparam longint FULL_TURN = 64'sd360 <<< 23;
    localparam longint HALF_TURN = 64'sd180 <<< 23;
    localparam longint QUARTER_TURN = 64'sd90 <<< 23;
    localparam longint UNIT30 = 64'sd1 <<< 30;
    localparam longint UNIT40 = 64'sd1 <<< 40;
    localparam longint UNIT60 = 64'sd1 <<< 60;
    localparam longint DIST_CAP = 64'sd3373259426;

    typedef struct {
        logic [23:0] radius;
        longint lat1;
        longint lon1;
        longint lat2;
        longint lon2;
        bit typed;
        logic [31:0] want;
    } route_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [29:0] start_latitude;
    logic signed [30:0] start_longitude;
    logic signed [29:0] end_latitude;
    logic signed [30:0] end_longitude;
    logic done;
    logic [31:0] distance;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    longint arc_tab[ROM_LEN];
    longint gain_recip;
    longint pi_q40_m;
    longint deg_to_rad;
    logic [23:0] radius_m;

    logic [31:0] dist_q[$];
    int errors = 0;
    int checked = 0;
    int settings = 0;

    haversine_great_circle_distance DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint mul_round(longint a, longint b, int sh);
        bit neg;
        bit [63:0] ua;
        bit [63:0] ub;
        bit [127:0] p;
        longint r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        r = longint'({1'b0, p[62:0]});
        return neg ? -r : r;
    endfunction

    function automatic longint arctan_recip(bit [63:0] n);
        bit [63:0] p;
        bit [63:0] nn;
        bit [63:0] k;
        longint sum;
        p = (64'd1 << 62) / n;
        nn = n * n;
        k = 0;
        sum = 0;
        while (p != 0)
        begin
            if (k[0])
                sum -= longint'(p / (2 * k + 1));
            else
                sum += longint'(p / (2 * k + 1));
            p = p / nn;
            k++;
        end
        return sum;
    endfunction

    function automatic void build_tables();
        longint pi60;
        longint prod;
        longint y;
        longint t;
        pi60 = 4 * arctan_recip(5) - arctan_recip(239);
        deg_to_rad = (pi60 + 90) / 180;
        pi_q40_m = (pi60 + (64'sd1 <<< 19)) >>> 20;
        arc_tab[0] = (pi60 + (64'sd1 <<< 21)) >>> 22;
        for (int i = 1; i < ROM_LEN; i++)
            arc_tab[i] = (arctan_recip(64'd1 << i) + (64'sd1 <<< 21)) >>> 22;
        prod = UNIT40;
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
            prod += prod >>> (2 * i);
        y = (3 * UNIT40) / 5;
        for (int i = 0; i < 10; i++)
        begin
            t = mul_round(prod, mul_round(y, y, 40), 40);
            y = mul_round(y, 3 * UNIT40 - t, 41);
        end
        gain_recip = y;
    endfunction

    function automatic longint to_q30(longint v);
        longint r;
        r = (v + 512) >>> 10;
        if (r > UNIT30)
            r = UNIT30;
        if (r < -UNIT30)
            r = -UNIT30;
        return r;
    endfunction

    function automatic void sin_cos_deg(longint ang, output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint z;
        longint xn;
        bit flip;
        flip = 0;
        r = ang % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        if (r > HALF_TURN)
            r -= FULL_TURN;
        if (r > QUARTER_TURN)
        begin
            r = HALF_TURN - r;
            flip = 1;
        end
        else if (r < -QUARTER_TURN)
        begin
            r = -HALF_TURN - r;
            flip = 1;
        end
        z = mul_round(r, deg_to_rad, 43);
        x = gain_recip;
        y = 0;
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= arc_tab[i];
            end
            else
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += arc_tab[i];
            end
            x = xn;
        end
        xn = x - mul_round(y, z, 40);
        y = y + mul_round(x, z, 40);
        s = to_q30(y);
        c = flip ? -to_q30(xn) : to_q30(xn);
    endfunction

    function automatic longint sqrt_nearest(bit [63:0] v);
        bit [63:0] root;
        bit [63:0] rem;
        bit [63:0] trial;
        root = 0;
        rem = 0;
        for (int j = 31; j >= 0; j--)
        begin
            rem = (rem << 2) | ((v >> (2 * j)) & 3);
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem -= trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        if (rem > root)
            root++;
        return longint'(root);
    endfunction

    function automatic longint atan2_q40(longint xa, longint ya);
        longint x;
        longint y;
        longint z;
        longint xn;
        x = xa * 1024;
        y = ya * 1024;
        z = 0;
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            if (y >= 0)
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += arc_tab[i];
            end
            else
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= arc_tab[i];
            end
            x = xn;
        end
        return z + mul_round(y, gain_recip, 40);
    endfunction

    function automatic logic [31:0] great_circle(logic signed [29:0] la1, logic signed [30:0] lo1,
                                                 logic signed [29:0] la2, logic signed [30:0] lo2);
        longint s1;
        longint s2;
        longint c1;
        longint c2;
        longint dummy;
        longint t;
        longint a;
        longint ang;
        longint d;
        sin_cos_deg(longint'(la2) - longint'(la1), s1, dummy);
        sin_cos_deg(longint'(lo2) - longint'(lo1), s2, dummy);
        sin_cos_deg(longint'(la1) * 2, dummy, c1);
        sin_cos_deg(longint'(la2) * 2, dummy, c2);
        t = mul_round(mul_round(c1, c2, 30), s2, 30);
        a = s1 * s1 + t * s2;
        if (a < 0)
            a = 0;
        if (a > UNIT60)
            a = UNIT60;
        ang = 2 * atan2_q40(sqrt_nearest(64'(UNIT60 - a)), sqrt_nearest(64'(a)));
        if (ang < 0)
            ang = 0;
        if (ang > pi_q40_m)
            ang = pi_q40_m;
        d = mul_round(longint'({40'd0, radius_m}), ang, 34);
        if (d < 0)
            d = 0;
        if (d > DIST_CAP)
            d = DIST_CAP;
        return d[31:0];
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: distance got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (dist_q.size() == 0)
                report("unexpected word", distance, 32'd0);
            else
            begin
                if (distance !== dist_q[0])
                    report("distance field", distance, dist_q[0]);
                void'(dist_q.pop_front());
                checked++;
            end
        end
    end

    task automatic drain();
        while (dist_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_radius(logic [23:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_RADIUS);
        pwdata <= {8'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        radius_m = value;
        settings++;
    endtask

    task automatic issue(longint la1, longint lo1, longint la2, longint lo2,
                         bit typed, logic [31:0] want);
        start <= 1'b1;
        start_latitude <= 30'(la1);
        start_longitude <= 31'(lo1);
        end_latitude <= 30'(la2);
        end_longitude <= 31'(lo2);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (typed)
            dist_q.push_back(want);
        else
            dist_q.push_back(great_circle(30'(la1), 31'(lo1), 30'(la2), 31'(lo2)));
    endtask

    function automatic longint pick_lat();
        if ($urandom_range(0, 99) < 85)
            return longint'($urandom_range(0, 2 * LAT_LIM)) - LAT_LIM;
        return longint'($signed(30'($urandom)));
    endfunction

    function automatic longint pick_lon();
        if ($urandom_range(0, 99) < 85)
            return longint'($urandom_range(0, 2 * LON_LIM)) - LON_LIM;
        return longint'($signed(31'($urandom)));
    endfunction

    route_row_t routes[] = '{
        '{24'd6371000, 0, 0, 0, 0, 0, 0},
        '{24'd6371000, 90 * DEG, 180 * DEG, -90 * DEG, -180 * DEG, 0, 0},
        '{24'd6371000, 0, 0, 0, 180 * DEG, 0, 0},
        '{24'd6371000, 90 * DEG, 0, -90 * DEG, 0, 0, 0},
        '{24'd6371000, 0, -180 * DEG, 0, 180 * DEG, 0, 0},
        '{24'd6371000, 0, 0, 1, 1, 0, 0},
        '{24'd6371000, 51 * DEG, 0, 40 * DEG, -74 * DEG, 0, 0},
        '{24'd6371000, 64'sd536870911, 64'sd1073741823, -64'sd536870912, -64'sd1073741824, 0, 0},
        '{24'd6371000, 64'sd536870911, 0, 64'sd536870911, 90 * DEG, 0, 0},
        '{24'd6371000, -64'sd536870912, 45 * DEG, 10 * DEG, -64'sd1073741824, 0, 0},
        '{24'd6371000, -LAT_LIM, LON_LIM, LAT_LIM, -LON_LIM, 0, 0},
        '{24'd16777215, 0, 0, 0, 180 * DEG, 0, 0},
        '{24'd16777215, 90 * DEG, 0, -90 * DEG, 0, 0, 0},
        '{24'd16777215, 30 * DEG, 20 * DEG, -45 * DEG, 170 * DEG, 0, 0},
        '{24'd0, 0, 0, 0, 180 * DEG, 1, 32'd0},
        '{24'd0, 12 * DEG, -33 * DEG, -70 * DEG, 99 * DEG, 1, 32'd0},
        '{24'd1, 0, 0, 0, 90 * DEG, 0, 0},
        '{24'd1, 0, 0, 0, 180 * DEG, 0, 0},
        '{24'd1, 1, 1, 0, 0, 0, 0}
    };

    logic [23:0] radius_plan[6] = '{24'd6371000, 24'd16777215, 24'd1, 24'd0, 24'd6371000, 24'd0};

    initial
    begin
        int burst;
        build_tables();
        radius_m = RADIUS_RESET;
        rst_n = 1'b0;
        start = 1'b0;
        start_latitude = '0;
        start_longitude = '0;
        end_latitude = '0;
        end_longitude = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (routes[i])
        begin
            if (routes[i].radius != radius_m)
            begin
                start <= 1'b0;
                write_radius(routes[i].radius);
            end
            issue(routes[i].lat1, routes[i].lon1, routes[i].lat2, routes[i].lon2,
                  routes[i].typed, routes[i].want);
            if (i % 3 == 2)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
        start <= 1'b0;

        radius_plan[5] = 24'($urandom_range(1, 24'hFFFFFF));
        for (int ph = 0; ph < 6; ph++)
        begin
            write_radius(radius_plan[ph]);
            for (int n = 0; n < 180; )
            begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst && n < 180; b++, n++)
                    issue(pick_lat(), pick_lon(), pick_lat(), pick_lon(), 0, 0);
                if ($urandom_range(0, 9) < 7)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            start <= 1'b0;
        end

        drain();
        $display("%0d distances checked across %0d radius settings", checked, settings);
        $display("directed extremes, poles, antipodes and out-of-range angles included");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
